[rtl/core/gbs_pkg.sv]
// Shared types and constants for the greedy box suppression block.
package gbs_pkg;

	localparam int MAX_KEPT_DEF  = 64;
	localparam int MAX_BOXES_DEF = 1024;
	localparam int COORD_W       = 16;
	localparam int THR_W         = 16;
	localparam int IDX_W         = 10;
	localparam int AREA_W        = 2 * COORD_W;
	localparam int BOX_W         = 4 * COORD_W;
	localparam logic [THR_W-1:0] THR_RESET = 16'd26214;

	// left edge in the lowest bits, matching the input word
	typedef struct packed {
		logic        [COORD_W-1:0] height;
		logic        [COORD_W-1:0] width;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] left;
	} box_t;

	typedef struct packed {
		logic vld;
		logic hit;
		logic busy;
	} iou_res_t;

endpackage

[rtl/core/greedy_box_suppression.sv]
// Greedy box suppression by overlap ratio: top level.
//
// Boxes enter on the s_axis channel one word at a time, sorted by falling
// score; tuser marks the first box of a frame and empties the kept list.
// Each box is checked against every box stored so far in its frame; the
// verdict leaves on m_axis with the box position in the frame.
// cfg_we/cfg_data write the overlap threshold (unsigned, 16 fraction bits);
// the user must write it only while the block is idle; the block does not enforce this.
//
// A box is checked against kept_count stored boxes (those kept so far in
// its frame, at most MAX_KEPT): they are read from the kept store one per
// cycle into a five stage compare pipeline. The box is accepted, its area is
// computed, the stored boxes are scanned, the pipeline drains and the result
// is registered; the block then returns to idle and takes the next box.
// One box is in work at a time.
// The result sits in an output register, so the next box is taken while a
// result waits; if the receiver stalls, the following box finishes its scan
// and then holds until the output register frees up.
// Reset empties the kept list, clears the box position and loads the
// default threshold; the kept store itself needs no clearing.
module greedy_box_suppression #(
	parameter int MAX_KEPT  = gbs_pkg::MAX_KEPT_DEF,
	parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // box_left, box_top, box_width, box_height
	input  logic        s_axis_tuser,   // frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // box_index, zero fill
	output logic [1:0]  m_axis_tuser,   // keep, list_full
	input  logic        cfg_we,
	input  logic [15:0] cfg_data        // overlap_threshold
);

	localparam int KA = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int KC = $clog2(MAX_KEPT + 1);
	localparam int BW = $clog2(MAX_BOXES);
	localparam int IW = gbs_pkg::IDX_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_AREA  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	gbs_pkg::box_t cur_q;
	logic [gbs_pkg::AREA_W-1:0] cur_area_q;
	logic [gbs_pkg::THR_W-1:0]  thr_q;
	logic [KC-1:0] kept_count_q, rd_idx_q;
	logic [BW-1:0] box_counter_q, pos_q, pos_c;
	logic [BW:0]   pos_inc;
	logic          drop_q, rd_vld_s1;
	logic          out_vld_q, keep_q, full_q;
	logic [IW-1:0] index_q;
	logic [BW+IW-1:0] pos_ext;
	logic          accept, rd_en, wr_en, room, out_free;
	gbs_pkg::box_t rd_box;
	gbs_pkg::iou_res_t iou_res;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign pos_c    = s_axis_tuser ? '0 : box_counter_q;
	assign pos_inc  = {1'b0, pos_c} + 1'b1;
	assign pos_ext  = {{IW{1'b0}}, pos_q};
	assign room     = kept_count_q < KC'(MAX_KEPT);
	assign out_free = !out_vld_q || m_axis_tready;
	assign rd_en    = (state_q == ST_SCAN) && (rd_idx_q != kept_count_q);
	assign wr_en    = (state_q == ST_DONE) && out_free && !drop_q && room;

	gbs_mem #(
		.DEPTH (MAX_KEPT),
		.AW    (KA)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (kept_count_q[KA-1:0]),
		.wdata (cur_q),
		.re    (rd_en),
		.raddr (rd_idx_q[KA-1:0]),
		.rdata (rd_box)
	);

	gbs_iou u_iou (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (rd_vld_s1),
		.cur      (cur_q),
		.cur_area (cur_area_q),
		.kept     (rd_box),
		.thr      (thr_q),
		.res      (iou_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			thr_q         <= gbs_pkg::THR_RESET;
			kept_count_q  <= '0;
			box_counter_q <= '0;
			rd_idx_q      <= '0;
			rd_vld_s1     <= 1'b0;
			drop_q        <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			rd_vld_s1 <= rd_en;
			if (iou_res.vld && iou_res.hit) begin
				drop_q <= 1'b1;
			end
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						drop_q        <= 1'b0;
						rd_idx_q      <= '0;
						box_counter_q <= (pos_inc >= (BW+1)'(MAX_BOXES)) ? '0 : pos_inc[BW-1:0];
						if (s_axis_tuser) begin
							kept_count_q <= '0;
						end
						state_q <= ST_AREA;
					end
				end
				ST_AREA: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !iou_res.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (wr_en) begin
							kept_count_q <= kept_count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= s_axis_tdata;
			pos_q <= pos_c;
		end
		if (state_q == ST_AREA) begin
			cur_area_q <= {{gbs_pkg::COORD_W{1'b0}}, cur_q.width} *
			              {{gbs_pkg::COORD_W{1'b0}}, cur_q.height};
		end
		if ((state_q == ST_DONE) && out_free) begin
			keep_q  <= !drop_q;
			full_q  <= !drop_q && !room;
			index_q <= pos_ext[IW-1:0];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(16-IW){1'b0}}, index_q};
	assign m_axis_tuser  = {full_q, keep_q};

endmodule

[rtl/core/gbs_mem.sv]
// Kept box store: one write port, one registered read port.
module gbs_mem #(
	parameter int DEPTH = gbs_pkg::MAX_KEPT_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  gbs_pkg::box_t            wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output gbs_pkg::box_t            rdata
);

	gbs_pkg::box_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/gbs_iou.sv]
// Pipelined overlap test of the current box against one stored box per cycle.
module gbs_iou (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  gbs_pkg::box_t                 cur,
	input  logic [gbs_pkg::AREA_W-1:0]    cur_area,
	input  gbs_pkg::box_t                 kept,
	input  logic [gbs_pkg::THR_W-1:0]     thr,
	output gbs_pkg::iou_res_t             res
);

	localparam int CW = gbs_pkg::COORD_W;
	localparam int AW = gbs_pkg::AREA_W;
	localparam int TW = gbs_pkg::THR_W;
	localparam int EW = CW + 2;

	logic signed [EW-1:0] al, bl, at, bt, ar, br, ab, bb;
	logic signed [EW-1:0] x0, x1, y0, y1, dx, dy;
	logic [CW-1:0] dx_c, dy_c;
	logic [AW-1:0] area_b_c, inter_c;
	logic [AW:0]   uni_c;
	logic [AW+TW:0] prod_c;

	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [CW-1:0] dx_s1, dy_s1;
	logic [AW-1:0] area_b_s1, area_b_s2, inter_s2, inter_s3, inter_s4;
	logic [AW:0]   uni_s3;
	logic [AW+TW:0] prod_s4;
	logic          hit_s5;

	always_comb begin
		al = {{2{cur.left[CW-1]}}, cur.left};
		bl = {{2{kept.left[CW-1]}}, kept.left};
		at = {{2{cur.top[CW-1]}}, cur.top};
		bt = {{2{kept.top[CW-1]}}, kept.top};
		ar = al + $signed({2'b00, cur.width});
		br = bl + $signed({2'b00, kept.width});
		ab = at + $signed({2'b00, cur.height});
		bb = bt + $signed({2'b00, kept.height});
		x0 = (al > bl) ? al : bl;
		y0 = (at > bt) ? at : bt;
		x1 = (ar < br) ? ar : br;
		y1 = (ab < bb) ? ab : bb;
		dx = x1 - x0;
		dy = y1 - y0;
		// positive overlap never exceeds either width, so it fits the field width
		dx_c = (dx > $signed(EW'(0))) ? dx[CW-1:0] : '0;
		dy_c = (dy > $signed(EW'(0))) ? dy[CW-1:0] : '0;
		area_b_c = {{CW{1'b0}}, kept.width} * {{CW{1'b0}}, kept.height};
		inter_c  = {{CW{1'b0}}, dx_s1} * {{CW{1'b0}}, dy_s1};
		uni_c    = {1'b0, cur_area} + {1'b0, area_b_s2} - {1'b0, inter_s2};
		prod_c   = {{(AW+1){1'b0}}, thr} * {{TW{1'b0}}, uni_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1     <= dx_c;
		dy_s1     <= dy_c;
		area_b_s1 <= area_b_c;
		inter_s2  <= inter_c;
		area_b_s2 <= area_b_s1;
		inter_s3  <= inter_s2;
		uni_s3    <= uni_c;
		inter_s4  <= inter_s3;
		prod_s4   <= prod_c;
		hit_s5    <= {1'b0, inter_s4, {TW{1'b0}}} > prod_s4;
	end

	assign res.vld  = vld_s5;
	assign res.hit  = hit_s5;
	assign res.busy = vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5;

endmodule
